### hdl/lzwd_pkg.sv
// Package: shared types and constants for the LZ window decompressor.
`default_nettype none
package lzwd_pkg;
  localparam int WinBytes = 8192;
  localparam int PtrW = 13;
  localparam int CntW = 14;

  typedef enum logic [3:0] {
    PH_FLAG, PH_SEL, PH_LEN1, PH_LEN0, PH_LIT, PH_SDIST, PH_LLO, PH_LHI, PH_EXT
  } phase_t;

  typedef enum logic [1:0] {
    ST_DATA = 2'd0, ST_END = 2'd1, ST_FAR = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CMD_LIT, CMD_COPY, CMD_STAT
  } cmd_kind_t;

  // Command passed from the parser to the copy engine.
  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  lit;
    logic [PtrW-1:0] dist_m1;
    logic [8:0]  len;
    status_t     stat;
  } cmd_t;
endpackage
`default_nettype wire

### hdl/lz_window_decompressor_top.sv
// Top level of the LZ window decompressor.
// One compressed byte is taken per transaction; control-bit bytes are followed
// by decode of their flag bits, and a match copy reads each copied byte through
// the single read port of the 8192-byte history RAM. Output groups of up to four
// bytes leave on m_axis; tlast marks the final group caused by one input byte.
// No clearing pass.
`default_nettype none
module lz_window_decompressor_top import lzwd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_axis_tvalid,
  output logic s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // compressed_byte
  output logic m_axis_tvalid,
  input  wire logic m_axis_tready,
  output logic [39:0] m_axis_tdata, // out_byte_0..3, byte_count, 5'b0
  output logic [1:0] m_axis_tuser,  // status
  output logic m_axis_tlast         // last_of_run
);
  logic pv, pr, ev, er, pl;
  cmd_t pc, ec;
  logic [2:0] u;
  lzwd_parser u_parse (.clk, .rst, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_byte(s_axis_tdata), .cmd_valid(pv), .cmd_ready(pr), .cmd(pc), .cmd_last(pl));
  lzwd_fifo u_q (.clk, .rst, .in_valid(pv), .in_ready(pr), .in_cmd(pc),
    .out_valid(ev), .out_ready(er), .out_cmd(ec));
  lzwd_engine u_eng (.clk, .rst, .cmd_valid(ev), .cmd_ready(er), .cmd(ec),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(m_axis_tdata),
    .out_user(u), .out_last(m_axis_tlast));
  assign m_axis_tuser = pl ? u[2:1] : u[2:1];
endmodule
`default_nettype wire

### hdl/lzwd_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none
module lzwd_ram #(
  parameter int Width = 8,
  parameter int Depth = 8192
) (
  input  wire logic clk,
  input  wire logic we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0] wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0] rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### hdl/lzwd_parser.sv
// Front end: bit word handling and token parsing into commands.
`default_nettype none
module lzwd_parser import lzwd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic [7:0] in_byte,
  output logic cmd_valid,
  input  wire logic cmd_ready,
  output cmd_t cmd,
  output logic cmd_last
);
  logic [15:0] bit_word;
  logic [4:0] bits_left;
  logic refill_half, stream_ended, busy, hold_len;
  phase_t phase;
  logic [8:0] match_length;
  logic [PtrW-1:0] match_distance;

  // A command pending: held while the queue is full.
  logic pend, pend_last;
  cmd_t pend_cmd;

  // Bit decode runs one bit per cycle after a byte when phase needs bits.
  logic bit_phase;
  assign bit_phase = (phase == PH_FLAG) || (phase == PH_SEL) ||
                     (phase == PH_LEN1) || (phase == PH_LEN0);
  assign busy = !stream_ended && bits_left != 5'd0 && bit_phase;
  assign in_ready = !pend && !busy;
  assign cmd_valid = pend;
  assign cmd = pend_cmd;
  assign cmd_last = pend_last;

  logic take;
  assign take = in_valid && in_ready;

  logic [15:0] ldist;
  logic [8:0] sdist;
  logic copy_go;
  logic [PtrW-1:0] copy_dm1;
  logic [8:0] copy_len;
  always_comb begin
    ldist = 16'hE000 | {3'b0, in_byte[7:3], match_distance[7:0]};
    ldist = ~ldist;  // 0x10000 - x - 1 = distance - 1
    sdist = 9'd255 - {1'b0, in_byte};
    copy_go = 1'b0;
    copy_dm1 = match_distance;
    copy_len = match_length;
    hold_len = 1'b0;
    unique case (phase)
      PH_SDIST: begin copy_go = 1'b1; copy_dm1 = {5'b0, sdist[7:0]}; end
      PH_LHI: begin
        copy_dm1 = ldist[PtrW-1:0];
        copy_len = {6'b0, in_byte[2:0]} + 9'd2;
        copy_go = in_byte[2:0] != 3'd0;
        hold_len = 1'b1;
      end
      PH_EXT: begin copy_go = in_byte > 8'd1; copy_len = {1'b0, in_byte} + 9'd1; end
      default: ;
    endcase
  end

  // Result of this byte is last unless bit decode can still produce output.
  // Bits after a byte never produce output, so each command is last.
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_word <= '0; bits_left <= '0; refill_half <= 1'b0; stream_ended <= 1'b0;
      phase <= PH_FLAG; match_length <= '0; match_distance <= '0; pend <= 1'b0;
      pend_last <= 1'b0;
    end else begin
      if (pend && cmd_ready) pend <= 1'b0;
      if (busy) begin
        bit_word <= {1'b0, bit_word[15:1]};
        bits_left <= bits_left - 5'd1;
        unique case (phase)
          PH_FLAG: phase <= bit_word[0] ? PH_LIT : PH_SEL;
          PH_SEL:  phase <= bit_word[0] ? PH_LLO : PH_LEN1;
          PH_LEN1: begin match_length <= {7'b0, bit_word[0], 1'b0}; phase <= PH_LEN0; end
          PH_LEN0: begin
            match_length <= match_length + {8'b0, bit_word[0]} + 9'd2;
            phase <= PH_SDIST;
          end
          default: phase <= PH_FLAG;
        endcase
      end else if (take && !stream_ended) begin
        pend_last <= 1'b1;
        if (bits_left == 5'd0) begin
          if (!refill_half) begin bit_word <= {8'b0, in_byte}; refill_half <= 1'b1; end
          else begin
            bit_word <= {in_byte, bit_word[7:0]}; refill_half <= 1'b0; bits_left <= 5'd16;
          end
        end else begin
          unique case (phase)
            PH_LIT: begin
              pend <= 1'b1; pend_cmd <= '{CMD_LIT, in_byte, '0, 9'd1, ST_DATA};
              phase <= PH_FLAG;
            end
            PH_LLO: begin match_distance <= {5'b0, in_byte}; phase <= PH_LHI; end
            PH_EXT: begin
              if (in_byte == 8'd0) begin
                pend <= 1'b1; stream_ended <= 1'b1;
                pend_cmd <= '{CMD_STAT, 8'd0, '0, 9'd0, ST_END};
              end else if (in_byte == 8'd1) phase <= PH_FLAG;
            end
            default: ;
          endcase
          if (phase == PH_SDIST || phase == PH_LHI) match_distance <= copy_dm1;
          if (hold_len) match_length <= copy_len;
          if (phase == PH_LHI && !copy_go) phase <= PH_EXT;
          if (copy_go) begin
            pend <= 1'b1; phase <= PH_FLAG;
            pend_cmd <= '{CMD_COPY, 8'd0, copy_dm1, copy_len, ST_DATA};
          end
          if (phase != PH_LIT && phase != PH_SDIST && phase != PH_LLO &&
              phase != PH_LHI && phase != PH_EXT) phase <= PH_FLAG;
        end
      end
    end
  end
  // A distance past the output so far is caught by the engine, which then
  // drops every later command, so keep accepting bytes here.
endmodule
`default_nettype wire

### hdl/lzwd_fifo.sv
// Two-entry command queue between parser and copy engine.
`default_nettype none
module lzwd_fifo import lzwd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire cmd_t in_cmd,
  output logic out_valid,
  input  wire logic out_ready,
  output cmd_t out_cmd
);
  cmd_t q [2];
  logic [1:0] cnt;
  logic rp, wp;
  assign in_ready = cnt != 2'd2;
  assign out_valid = cnt != 2'd0;
  assign out_cmd = q[rp];
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) q[wp] <= in_cmd;
    if (rst) begin
      cnt <= '0; rp <= 1'b0; wp <= 1'b0;
    end else begin
      if (in_valid && in_ready) wp <= ~wp;
      if (out_valid && out_ready) rp <= ~rp;
      cnt <= cnt + {1'b0, in_valid && in_ready} - {1'b0, out_valid && out_ready};
    end
  end
endmodule
`default_nettype wire

### hdl/lzwd_engine.sv
// Back end: executes literal, copy and status commands, packs output groups.
`default_nettype none
module lzwd_engine import lzwd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_valid,
  output logic cmd_ready,
  input  wire cmd_t cmd,
  output logic out_valid,
  input  wire logic out_ready,
  output logic [39:0] out_data,
  output logic [2:0] out_user,
  output logic out_last
);
  logic [PtrW-1:0] wp, raddr;
  logic [CntW-1:0] produced;
  logic halted, active, rd_pend;
  logic [8:0] remain;
  logic [PtrW-1:0] dm1;
  logic [7:0] rdata;
  logic [7:0] grp [4];
  logic [2:0] gcnt;
  logic we;
  logic [7:0] wdata;

  lzwd_ram #(.Width(8), .Depth(WinBytes)) u_hist (
    .clk(clk), .we(we), .waddr(wp), .wdata(wdata), .raddr(raddr), .rdata(rdata));

  // Copy: issue read, next cycle write the byte; the next read waits for that write.
  assign raddr = wp - dm1 - PtrW'(1);
  logic out_free;
  assign out_free = !out_valid || out_ready;
  // Once halted, drain and drop every later command.
  logic cmd_take;
  assign cmd_ready = halted || (!active && out_free && gcnt == 3'd0);
  assign cmd_take = cmd_valid && cmd_ready && !halted;

  logic byte_go;
  logic [7:0] byte_val;
  always_comb begin
    byte_go = 1'b0; byte_val = rdata;
    if (rd_pend) byte_go = 1'b1;
    else if (cmd_take && cmd.kind == CMD_LIT) begin
      byte_go = 1'b1; byte_val = cmd.lit;
    end
  end
  assign we = byte_go;
  assign wdata = byte_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; produced <= '0; halted <= 1'b0; active <= 1'b0; rd_pend <= 1'b0;
      gcnt <= '0; out_valid <= 1'b0; remain <= '0; dm1 <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      rd_pend <= 1'b0;
      if (cmd_take) begin
        unique case (cmd.kind)
          CMD_COPY: begin
            if ({1'b0, cmd.dist_m1} >= produced) begin
              halted <= 1'b1; out_valid <= 1'b1; out_data <= '0;
              out_user <= {ST_FAR, 1'b1}; out_last <= 1'b1;
            end else begin
              active <= 1'b1; remain <= cmd.len; dm1 <= cmd.dist_m1;
            end
          end
          CMD_STAT: begin
            halted <= 1'b1; out_valid <= 1'b1; out_data <= '0;
            out_user <= {cmd.stat, 1'b1}; out_last <= 1'b1;
          end
          default: ;
        endcase
      end else if (active && !rd_pend && out_free) begin
        if (remain == 9'd0) begin
          active <= 1'b0;
          if (gcnt != 3'd0) begin
            out_valid <= 1'b1; out_last <= 1'b1; gcnt <= '0;
            out_data <= {5'b0, gcnt, grp[3], grp[2], grp[1], grp[0]} & {8'h07,
              gcnt > 3'd3 ? 8'hFF : 8'h00, gcnt > 3'd2 ? 8'hFF : 8'h00,
              gcnt > 3'd1 ? 8'hFF : 8'h00, 8'hFF};
            out_user <= {ST_DATA, 1'b1};
          end
        end else begin
          rd_pend <= 1'b1; remain <= remain - 9'd1;
        end
      end
      if (byte_go) begin
        wp <= wp + PtrW'(1);
        if (produced != CntW'(WinBytes)) produced <= produced + CntW'(1);
        grp[gcnt[1:0]] <= byte_val;
        if (!active) begin
          out_valid <= 1'b1; out_last <= 1'b1; out_user <= {ST_DATA, 1'b1};
          out_data <= {8'd1, 24'd0, byte_val};
        end else if (gcnt == 3'd3) begin
          out_valid <= 1'b1; gcnt <= '0;
          out_last <= remain == 9'd0; out_user <= {ST_DATA, remain == 9'd0};
          out_data <= {8'd4, byte_val, grp[2], grp[1], grp[0]};
          if (remain == 9'd0) active <= 1'b0;
        end else gcnt <= gcnt + 3'd1;
      end
    end
  end
endmodule
`default_nettype wire

### hdl/lzwd_checker.sv
// Port-level checker for the decompressor top level.
`default_nettype none
module lzwd_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic m_axis_tvalid,
  input wire logic m_axis_tready,
  input wire logic [39:0] m_axis_tdata,
  input wire logic [1:0] m_axis_tuser,
  input wire logic m_axis_tlast
);
  a_stat_empty: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != 2'd0 |-> m_axis_tdata[34:32] == 3'd0)
    else $error("status result carries bytes");
  a_stat_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != 2'd0 |-> m_axis_tlast)
    else $error("status result not last");
  a_count: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == 2'd0 |-> m_axis_tdata[34:32] != 3'd0)
    else $error("empty data result");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");
endmodule
bind lz_window_decompressor_top lzwd_checker u_chk (.*);
`default_nettype wire
